/* sv/kcat_pkg.sv */
// shared types and codes for the keyed cost accumulator table
// no dependencies; imported by every module of the block
package kcat_pkg;

	localparam logic MODE_RECORD = 1'b0;
	localparam logic MODE_CLEAR  = 1'b1;

	localparam logic [1:0] OUTC_HIT   = 2'd0;
	localparam logic [1:0] OUTC_FILL  = 2'd1;
	localparam logic [1:0] OUTC_EVICT = 2'd2;
	localparam logic [1:0] OUTC_CLEAR = 2'd3;

	// request queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef struct packed {
		logic        mode;
		logic [63:0] key;
		logic [31:0] tag;
		logic [63:0] pcost;
		logic [63:0] scost;
	} item_t;

	typedef struct packed {
		logic  valid;
		logic  is_clear;
		item_t item;
	} req_t;

	typedef struct packed {
		logic [63:0] key;
		logic [31:0] tag;
		logic [63:0] psum;
		logic [63:0] ssum;
		logic [31:0] samples;
	} row_t;

endpackage

/* sv/keyed_cost_accumulator_table.sv */
// top level of the keyed cost accumulator table
// depends on kcat_pkg, kcat_front and kcat_back
//
// usage:
//   request channel: drive mode, key, tag, primary_cost, secondary_cost and
//   raise start; the request is taken at a rising edge where start is high
//   and busy is low. busy is high while the two-entry request queue is full.
//   result channel: done is high for one cycle with slot_index, outcome,
//   primary_sum, secondary_sum and sample_count; the receiver cannot stall,
//   so results must be taken in the cycle they appear.
// operation:
//   a record request scans the table one slot per cycle through the slot
//   memory read port, then writes the chosen slot and registers the result.
//   a clear request is taken in the idle state and its result registered;
//   clears can follow one per cycle. requests queue up while the table
//   works on an earlier one.
// reset:
//   arst_n low empties the queue and marks every slot empty at once through
//   per-slot valid bits; no clearing pass is needed.
module keyed_cost_accumulator_table import kcat_pkg::*; #(
	parameter int ENTRIES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        mode,
	input  logic [63:0] key,
	input  logic [31:0] tag,
	input  logic [63:0] primary_cost,
	input  logic [63:0] secondary_cost,
	output logic        done,
	output logic [2:0]  slot_index,
	output logic [1:0]  outcome,
	output logic [63:0] primary_sum,
	output logic [63:0] secondary_sum,
	output logic [31:0] sample_count
);

	item_t item_in;
	req_t  head;
	logic  pop;

	assign item_in.mode  = mode;
	assign item_in.key   = key;
	assign item_in.tag   = tag;
	assign item_in.pcost = primary_cost;
	assign item_in.scost = secondary_cost;

	kcat_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item_in (item_in),
		.pop     (pop),
		.head    (head)
	);

	kcat_back #(
		.ENTRIES (ENTRIES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.done          (done),
		.slot_index    (slot_index),
		.outcome       (outcome),
		.primary_sum   (primary_sum),
		.secondary_sum (secondary_sum),
		.sample_count  (sample_count)
	);

endmodule

/* sv/kcat_front.sv */
// front part: takes requests, classifies them and holds them in a short queue
// depends on kcat_pkg
module kcat_front import kcat_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	input  item_t item_in,
	input  logic  pop,
	output req_t  head
);

	typedef struct packed {
		logic  is_clear;
		item_t item;
	} entry_t;

	entry_t              q_mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     cnt_q;
	logic                push;
	logic                take;

	assign busy = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign push = start && !busy;
	assign take = pop && (cnt_q != '0);

	assign head.valid    = (cnt_q != '0);
	assign head.is_clear = q_mem_q[rd_ptr_q].is_clear;
	assign head.item     = q_mem_q[rd_ptr_q].item;

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q].is_clear <= (item_in.mode == MODE_CLEAR);
			q_mem_q[wr_ptr_q].item     <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (take)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !take)
				cnt_q <= cnt_q + 1'b1;
			else if (take && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* sv/kcat_back.sv */
// back part: slot table, sequential slot scan and update, result register
// depends on kcat_pkg
module kcat_back import kcat_pkg::*; #(
	parameter int ENTRIES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  req_t        head,
	output logic        pop,
	output logic        done,
	output logic [2:0]  slot_index,
	output logic [1:0]  outcome,
	output logic [63:0] primary_sum,
	output logic [63:0] secondary_sum,
	output logic [31:0] sample_count
);

	localparam int IDX_W = $clog2(ENTRIES);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_WRITE
	} state_t;

	state_t             state_q;
	item_t              cur_q;
	logic [IDX_W-1:0]   scan_idx_q;
	logic [ENTRIES-1:0] occ_q;

	// slot storage, one row per slot
	row_t               mem [ENTRIES];
	row_t               rd_row_s1;
	logic               rd_live_s1;
	logic               rd_occ_s1;
	logic [IDX_W-1:0]   rd_idx_s1;

	logic               hit_fnd_q;
	logic [IDX_W-1:0]   hit_idx_q;
	row_t               hit_row_q;
	logic               emp_fnd_q;
	logic [IDX_W-1:0]   emp_idx_q;
	row_t               emp_row_q;
	logic [IDX_W-1:0]   min_idx_q;
	logic [63:0]        min_p_q;

	logic               done_q;
	logic [2:0]         slot_index_q;
	logic [1:0]         outcome_q;
	logic [63:0]        psum_q;
	logic [63:0]        ssum_q;
	logic [31:0]        samples_q;

	row_t               row_eff;
	logic               occupied;
	logic               match;
	row_t               base_row;
	row_t               new_row;
	logic [IDX_W-1:0]   sel_idx;
	logic [1:0]         sel_outc;
	logic [IDX_W+2:0]   sel_ext;
	logic               wr_en;

	assign pop = (state_q == ST_IDLE) && head.valid;

	// a slot without its valid bit reads as all zero
	assign row_eff  = rd_occ_s1 ? rd_row_s1 : '0;
	assign occupied = rd_occ_s1 && (row_eff.samples != '0);
	assign match    = occupied && (row_eff.key == cur_q.key);

	always_comb begin
		if (hit_fnd_q) begin
			base_row = hit_row_q;
			sel_idx  = hit_idx_q;
			sel_outc = OUTC_HIT;
		end else if (emp_fnd_q) begin
			base_row = emp_row_q;
			sel_idx  = emp_idx_q;
			sel_outc = OUTC_FILL;
		end else begin
			base_row = '0;
			sel_idx  = min_idx_q;
			sel_outc = OUTC_EVICT;
		end
		new_row.key     = cur_q.key;
		new_row.tag     = cur_q.tag;
		new_row.psum    = base_row.psum + cur_q.pcost;
		new_row.ssum    = base_row.ssum + cur_q.scost;
		new_row.samples = base_row.samples + 32'd1;
	end

	assign sel_ext = {3'b000, sel_idx};
	assign wr_en   = (state_q == ST_WRITE);

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[sel_idx] <= new_row;
		rd_row_s1 <= mem[scan_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cur_q        <= '0;
			scan_idx_q   <= '0;
			occ_q        <= '0;
			rd_live_s1   <= 1'b0;
			rd_occ_s1    <= 1'b0;
			rd_idx_s1    <= '0;
			hit_fnd_q    <= 1'b0;
			hit_idx_q    <= '0;
			hit_row_q    <= '0;
			emp_fnd_q    <= 1'b0;
			emp_idx_q    <= '0;
			emp_row_q    <= '0;
			min_idx_q    <= '0;
			min_p_q      <= '0;
			done_q       <= 1'b0;
			slot_index_q <= '0;
			outcome_q    <= OUTC_HIT;
			psum_q       <= '0;
			ssum_q       <= '0;
			samples_q    <= '0;
		end else begin
			done_q     <= 1'b0;
			rd_live_s1 <= (state_q == ST_SCAN);
			rd_occ_s1  <= occ_q[scan_idx_q];
			rd_idx_s1  <= scan_idx_q;

			// fold in the slot read last cycle
			if (rd_live_s1) begin
				if (match && !hit_fnd_q) begin
					hit_fnd_q <= 1'b1;
					hit_idx_q <= rd_idx_s1;
					hit_row_q <= row_eff;
				end
				if (!occupied && !emp_fnd_q) begin
					emp_fnd_q <= 1'b1;
					emp_idx_q <= rd_idx_s1;
					emp_row_q <= row_eff;
				end
				// strict less-than keeps the lowest index on a tie
				if (rd_idx_s1 == '0 || row_eff.psum < min_p_q) begin
					min_idx_q <= rd_idx_s1;
					min_p_q   <= row_eff.psum;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						cur_q <= head.item;
						if (head.is_clear) begin
							occ_q        <= '0;
							done_q       <= 1'b1;
							slot_index_q <= '0;
							outcome_q    <= OUTC_CLEAR;
							psum_q       <= '0;
							ssum_q       <= '0;
							samples_q    <= '0;
						end else begin
							scan_idx_q <= '0;
							hit_fnd_q  <= 1'b0;
							emp_fnd_q  <= 1'b0;
							state_q    <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (scan_idx_q == IDX_W'(ENTRIES - 1))
						state_q <= ST_DRAIN;
					else
						scan_idx_q <= scan_idx_q + 1'b1;
				end
				ST_DRAIN: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					occ_q[sel_idx] <= 1'b1;
					done_q         <= 1'b1;
					slot_index_q   <= sel_ext[2:0];
					outcome_q      <= sel_outc;
					psum_q         <= new_row.psum;
					ssum_q         <= new_row.ssum;
					samples_q      <= new_row.samples;
					state_q        <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done          = done_q;
	assign slot_index    = slot_index_q;
	assign outcome       = outcome_q;
	assign primary_sum   = psum_q;
	assign secondary_sum = ssum_q;
	assign sample_count  = samples_q;

endmodule

/* sv/kcat_checker.sv */
// port-level checks for the keyed cost accumulator table, bound to the top
// depends on kcat_pkg
module kcat_checker import kcat_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        busy,
	input logic        done,
	input logic [2:0]  slot_index,
	input logic [1:0]  outcome,
	input logic [63:0] primary_sum,
	input logic [63:0] secondary_sum,
	input logic [31:0] sample_count
);

	// a clear reports an all-zero slot
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && outcome == OUTC_CLEAR |-> slot_index == 3'd0 && primary_sum == 64'd0 &&
			secondary_sum == 64'd0 && sample_count == 32'd0)
		else $error("clear result not zero");

	// a fresh or evicted slot holds exactly one sample
	a_new_slot_one: assert property (@(posedge clk) disable iff (!arst_n)
		done && (outcome == OUTC_FILL || outcome == OUTC_EVICT) |-> sample_count == 32'd1)
		else $error("new slot sample count not one");

	// nothing pending right after reset
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !done && !busy)
		else $error("activity right after reset");

endmodule

bind keyed_cost_accumulator_table kcat_checker u_kcat_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.busy          (busy),
	.done          (done),
	.slot_index    (slot_index),
	.outcome       (outcome),
	.primary_sum   (primary_sum),
	.secondary_sum (secondary_sum),
	.sample_count  (sample_count)
);
